// ===== design/pfss_pkg.sv =====
// Package for the pad field source scheduler: field widths, source and mode codes, register map.
package pfss_pkg;

   localparam int BurstWidth    = 8;
   localparam int IntervalWidth = 16;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;

   localparam logic [BurstWidth-1:0]    BurstLenReset       = 8'd8;
   localparam logic [IntervalWidth-1:0] RetxIntervalReset   = 16'd50;
   localparam logic [IntervalWidth-1:0] RotateIntervalReset = 16'd40;
   localparam logic [IntervalWidth-1:0] CountMax            = 16'hFFFF;

   typedef enum logic [1:0] {
      SRC_NONE  = 2'd0,
      SRC_SLIDE = 2'd1,
      SRC_SPI   = 2'd2,
      SRC_TEXT  = 2'd3
   } source_type;

   typedef enum logic [1:0] {
      MODE_FIELD_REQ  = 2'd0,
      MODE_SLIDE_LOAD = 2'd1,
      MODE_TEXT_LOAD  = 2'd2,
      MODE_UNUSED     = 2'd3
   } mode_type;

   localparam logic [CsrIndexWidth-1:0] REG_BURST_LEN       = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_RETX_INTERVAL   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_ROTATE_INTERVAL = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_SPI_ENABLED     = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_EPG_ENABLED     = 3'd4;

endpackage

// ===== design/pad_field_source_scheduler.sv =====
// Pad field source scheduler: picks slideshow, service info, text or no source for every field request.
// Path: a transaction accepted on req_ sits in the input register, is decided from there and
// is then registered into the result register, which offers it on rsp_.
// Throughput: one transaction per cycle while rsp_tready holds; the input register and the
// result register let a new request enter while a finished result still waits for rsp_tready.
// Reset: synchronous, active high; clears scheduler state and both stages, loads defaults.
module pad_field_source_scheduler (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // [0] slide_has_field,
                                                            // [1] spi_has_field,
                                                            // [2] dls_has_field,
                                                            // [3] epg_text_ready, [7:4] zero
   input  logic [1:0]                           req_tuser,  // [1:0] mode
   // Result channel.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [7:0]                           rsp_tdata,  // [1:0] source, [2] restart_slide,
                                                            // [3] restart_spi,
                                                            // [4] show_guide_text,
                                                            // [5] text_reload, [7:6] zero
   // Configuration write channel.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pfss_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [pfss_pkg::CsrDataWidth-1:0]    csr_wdata
);
   import pfss_pkg::*;

   // Configuration registers.
   logic [BurstWidth-1:0]    burst_len_ff;
   logic [IntervalWidth-1:0] retx_interval_ff;
   logic [IntervalWidth-1:0] rotate_interval_ff;
   logic                     spi_enabled_ff;
   logic                     epg_enabled_ff;

   // Scheduler state.
   logic [BurstWidth-1:0]    burst_count_ff,   burst_count_in;
   logic [IntervalWidth-1:0] idle_count_ff,    idle_count_in;
   logic [IntervalWidth-1:0] rotate_count_ff,  rotate_count_in;
   logic                     slide_loaded_ff,  slide_loaded_in;
   logic                     text_loaded_ff,   text_loaded_in;
   logic                     slide_active_ff,  slide_active_in;
   logic                     spi_running_ff,   spi_running_in;
   logic                     spi_turn_next_ff, spi_turn_next_in;
   logic                     guide_showing_ff, guide_showing_in;

   // Input stage.
   logic                     in_vld_ff;
   mode_type                 in_mode_ff;
   logic                     in_slide_rdy_ff;
   logic                     in_spi_rdy_ff;
   logic                     in_dls_rdy_ff;
   logic                     in_epg_rdy_ff;

   // Result stage.
   logic                     out_vld_ff;
   source_type               out_source_ff;
   logic                     out_restart_slide_ff;
   logic                     out_restart_spi_ff;
   logic                     out_guide_ff;
   logic                     out_reload_ff;

   // Decision of the item in the input stage.
   source_type               source_in;
   logic                     restart_slide_in;
   logic                     restart_spi_in;
   logic                     reload_in;

   logic                     advance;

   // The input stage moves into the result stage whenever the result stage is free or
   // its transaction is taken in this same cycle.
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {2'b00, out_reload_ff, out_guide_ff, out_restart_spi_ff,
                        out_restart_slide_ff, out_source_ff};

   // One pass through the scheduling policy, in the same order as the state is updated:
   // text rotation, then the retransmission timer, then the carousel burst, then text fill.
   always_comb begin
      source_type active;
      logic       has;
      logic       served;
      logic       finished;

      burst_count_in   = burst_count_ff;
      idle_count_in    = idle_count_ff;
      rotate_count_in  = rotate_count_ff;
      slide_loaded_in  = slide_loaded_ff;
      text_loaded_in   = text_loaded_ff;
      slide_active_in  = slide_active_ff;
      spi_running_in   = spi_running_ff;
      spi_turn_next_in = spi_turn_next_ff;
      guide_showing_in = guide_showing_ff;
      source_in        = SRC_NONE;
      restart_slide_in = 1'b0;
      restart_spi_in   = 1'b0;
      reload_in        = 1'b0;
      active           = SRC_NONE;
      has              = 1'b0;
      served           = 1'b0;
      finished         = 1'b0;

      case (in_mode_ff)
         MODE_SLIDE_LOAD: begin
            slide_loaded_in = 1'b1;
            slide_active_in = 1'b1;
            spi_running_in  = 1'b0;
            burst_count_in  = '0;
            idle_count_in   = '0;
         end
         MODE_TEXT_LOAD: begin
            text_loaded_in   = 1'b1;
            guide_showing_in = 1'b0;
            reload_in        = 1'b1;
         end
         MODE_FIELD_REQ: begin
            // Station and guide text swap; guide text is entered only when it is ready.
            if (epg_enabled_ff && text_loaded_ff) begin
               if (rotate_count_in != CountMax) begin
                  rotate_count_in = rotate_count_in + IntervalWidth'(1);
               end
               if (rotate_count_in >= rotate_interval_ff) begin
                  rotate_count_in = '0;
                  if (guide_showing_in) begin
                     guide_showing_in = 1'b0;
                     reload_in        = 1'b1;
                  end else if (in_epg_rdy_ff) begin
                     guide_showing_in = 1'b1;
                     reload_in        = 1'b1;
                  end
               end
            end

            // With no carousel running, count idle requests and restart one at the interval.
            if (!slide_active_in && !spi_running_in) begin
               if (idle_count_in != CountMax) begin
                  idle_count_in = idle_count_in + IntervalWidth'(1);
               end
               if (idle_count_in >= retx_interval_ff) begin
                  if (spi_turn_next_in && spi_enabled_ff) begin
                     restart_spi_in   = 1'b1;
                     spi_running_in   = 1'b1;
                     spi_turn_next_in = 1'b0;
                  end else if (slide_loaded_in) begin
                     restart_slide_in = 1'b1;
                     slide_active_in  = 1'b1;
                     spi_turn_next_in = spi_enabled_ff;
                  end else if (spi_enabled_ff) begin
                     restart_spi_in = 1'b1;
                     spi_running_in = 1'b1;
                  end
                  burst_count_in = '0;
                  idle_count_in  = '0;
               end
            end

            // A carousel restarted in this request counts as having a field ready.
            if (slide_active_in && slide_loaded_in) begin
               active = SRC_SLIDE;
               has    = in_slide_rdy_ff || restart_slide_in;
            end else if (spi_running_in && spi_enabled_ff) begin
               active = SRC_SPI;
               has    = in_spi_rdy_ff || restart_spi_in;
            end

            if (active != SRC_NONE) begin
               if (burst_count_in < burst_len_ff) begin
                  if (has) begin
                     burst_count_in = burst_count_in + BurstWidth'(1);
                     source_in      = active;
                     served         = 1'b1;
                  end else begin
                     finished = 1'b1;
                  end
               end else begin
                  // Burst is over: one text field goes in between, if text can give one.
                  burst_count_in = '0;
                  if (text_loaded_in && in_dls_rdy_ff) begin
                     source_in = SRC_TEXT;
                     served    = 1'b1;
                  end else if (has) begin
                     burst_count_in = {{(BurstWidth-1){1'b0}}, 1'b1};
                     source_in      = active;
                     served         = 1'b1;
                  end else begin
                     finished = 1'b1;
                  end
               end

               // A finished carousel goes idle, except that a loaded slideshow starts over.
               if (finished) begin
                  slide_active_in = 1'b0;
                  spi_running_in  = 1'b0;
                  idle_count_in   = '0;
                  if (slide_loaded_in) begin
                     restart_slide_in = 1'b1;
                     slide_active_in  = 1'b1;
                     burst_count_in   = {{(BurstWidth-1){1'b0}}, 1'b1};
                     source_in        = SRC_SLIDE;
                     served           = 1'b1;
                  end
               end
            end

            if (!served && text_loaded_in && in_dls_rdy_ff) begin
               source_in = SRC_TEXT;
            end
         end
         default: begin
            // The unused mode leaves the state as it is.
         end
      endcase
   end

   // Control state, state of the scheduler and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff          <= 1'b0;
         out_vld_ff         <= 1'b0;
         burst_count_ff     <= '0;
         idle_count_ff      <= '0;
         rotate_count_ff    <= '0;
         slide_loaded_ff    <= 1'b0;
         text_loaded_ff     <= 1'b0;
         slide_active_ff    <= 1'b0;
         spi_running_ff     <= 1'b0;
         spi_turn_next_ff   <= 1'b0;
         guide_showing_ff   <= 1'b0;
         burst_len_ff       <= BurstLenReset;
         retx_interval_ff   <= RetxIntervalReset;
         rotate_interval_ff <= RotateIntervalReset;
         spi_enabled_ff     <= 1'b0;
         epg_enabled_ff     <= 1'b0;
      end else begin
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         if (advance) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
         if (advance) begin
            burst_count_ff   <= burst_count_in;
            idle_count_ff    <= idle_count_in;
            rotate_count_ff  <= rotate_count_in;
            slide_loaded_ff  <= slide_loaded_in;
            text_loaded_ff   <= text_loaded_in;
            slide_active_ff  <= slide_active_in;
            spi_running_ff   <= spi_running_in;
            spi_turn_next_ff <= spi_turn_next_in;
            guide_showing_ff <= guide_showing_in;
         end
         if (csr_valid) begin
            case (csr_index)
               REG_BURST_LEN:       burst_len_ff       <= csr_wdata[BurstWidth-1:0];
               REG_RETX_INTERVAL:   retx_interval_ff   <= csr_wdata[IntervalWidth-1:0];
               REG_ROTATE_INTERVAL: rotate_interval_ff <= csr_wdata[IntervalWidth-1:0];
               REG_SPI_ENABLED:     spi_enabled_ff     <= csr_wdata[0];
               REG_EPG_ENABLED:     epg_enabled_ff     <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload of both pipeline stages.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_mode_ff      <= mode_type'(req_tuser);
         in_slide_rdy_ff <= req_tdata[0];
         in_spi_rdy_ff   <= req_tdata[1];
         in_dls_rdy_ff   <= req_tdata[2];
         in_epg_rdy_ff   <= req_tdata[3];
      end
      if (advance) begin
         out_source_ff        <= source_in;
         out_restart_slide_ff <= restart_slide_in;
         out_restart_spi_ff   <= restart_spi_in;
         out_guide_ff         <= guide_showing_in;
         out_reload_ff        <= reload_in;
      end
   end

`ifndef SYNTHESIS
   // A decided transaction always lands in the result stage.
   assert property (@(posedge clock) disable iff (reset) advance |=> out_vld_ff)
      else $error("decided transaction did not reach the result stage");

   // At most one carousel runs at a time.
   assert property (@(posedge clock) disable iff (reset) !(slide_active_ff && spi_running_ff))
      else $error("slideshow and service info carousels both running");

   // Only one carousel is restarted by any one request.
   assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> !(out_restart_slide_ff && out_restart_spi_ff))
      else $error("both carousels restarted in one step");

   // An empty result stage never holds off new requests.
   assert property (@(posedge clock) disable iff (reset) !out_vld_ff |-> req_tready)
      else $error("request stalled while result stage is empty");
`endif

endmodule
